// ===== rtl/core/gmca_pkg.sv =====
// ----------------------------------------------------------------------------
// Gated min-cost assignment: shared package
// Types, codes and constants used by the column cells and the top level.
// ----------------------------------------------------------------------------
package gmca_pkg;

  // Potentials and slacks are signed 32-bit integers.
  localparam int POT_W = 32;
  typedef logic signed [POT_W-1:0] pot_t;

  // Largest slack value, used as "no slack seen yet".
  localparam pot_t SLACK_MAX = {1'b0, {(POT_W-1){1'b1}}};

  // Request command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_COST  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_PAIR    = 2'd0;
  localparam logic [1:0] KIND_ROW     = 2'd1;
  localparam logic [1:0] KIND_COL     = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_MARK,
    ST_SCAN,
    ST_WAIT,
    ST_UPD,
    ST_AUG_A,
    ST_AUG_B,
    ST_CHK_A,
    ST_CHK_B,
    ST_EM_PAIR,
    ST_EM_ROW,
    ST_EM_COL
  } state_e;

  // Broadcast commands from the sequencer to every column cell.
  typedef struct packed {
    logic clear_job;  // zero potentials, owners and links
    logic row_init;   // start of a row pass
    logic mark;       // mark one column visited
    logic update;     // apply the step delta
    logic write;      // move an owner along the augmenting path
  } cell_ctrl_t;

endpackage

// ===== rtl/core/gated_min_cost_assignment.sv =====
// ----------------------------------------------------------------------------
// Gated min-cost assignment (Kuhn-Munkres, shortest augmenting path)
// Loads a cost matrix, solves the assignment and lists kept pairs and
// unmatched rows and columns.
// ----------------------------------------------------------------------------
// Requests are taken only in the idle state, whenever one is offered. The
// last cost request starts the solve, during which no request is taken. The
// solve runs one pass per row i = 1..n (n = max of the counts); each pass has
// a setup state and up to n+1 search steps, each paced by the scan packet
// crossing the MAX_DIM+1 column cells, and an augment walk through ST_AUG_A
// and ST_AUG_B per path column. A final gate check visits each of the n
// columns in ST_CHK_A then ST_CHK_B, then at most one result leaves per cycle
// while the output is taken: pairs, then unmatched rows, then unmatched columns.
// ----------------------------------------------------------------------------
module gated_min_cost_assignment #(
  parameter int MAX_DIM   = 16,
  parameter int COST_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [4:0]  row_count_i,
  input  logic [4:0]  col_count_i,
  input  logic [15:0] gate_threshold_i,
  input  logic [15:0] cost_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [3:0]  row_index_o,
  output logic [3:0]  col_index_o,
  output logic        last_of_run_o
);
  import gmca_pkg::*;

  localparam int IW    = $clog2(MAX_DIM+1);
  localparam int GW    = $clog2(MAX_DIM+2);
  localparam int PW    = $clog2(MAX_DIM*MAX_DIM+1);
  localparam int DEPTH = MAX_DIM*MAX_DIM;
  localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = IW + 1;

  // Sequencer registers.
  state_e           state_q, state_d;
  logic [IW-1:0]    rows_q, rows_d, cols_q, cols_d, n_q, n_d;
  logic [15:0]      gate_q, gate_d;
  logic [PW-1:0]    load_q, load_d;
  logic             active_q, active_d;
  logic [IW-1:0]    row_q, row_d, j0_q, j0_d, i0_q, i0_d, sc_q, sc_d;
  pot_t             u_q, u_d, delta_q, delta_d, pot1_q, pot1_d;
  logic [IW-1:0]    j1_q, j1_d, own1_q, own1_d, aj1_q, aj1_d;
  logic [GW-1:0]    guard_q, guard_d;
  logic [IW-1:0]    cj_q, cj_d, cown_q, cown_d, er_q, er_d, m_q, m_d;
  logic             ok_q, ok_d;
  logic [MAX_DIM:0] matched_q, matched_d, row_hit_q, row_hit_d;
  logic [TW-1:0]    ecnt_q, ecnt_d;

  // Output register.
  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic [3:0]       orow_q, ocol_q;
  logic             olast_q;
  logic             out_load;
  logic [1:0]       kind_n;
  logic [3:0]       orow_n, ocol_n;

  // Cost memory.
  logic [COST_BITS-1:0] cost_mem [DEPTH];
  logic [COST_BITS-1:0] rd_q;
  logic                 pad_q, pad_d;
  logic                 mem_we;
  logic [AW-1:0]        waddr, raddr;
  logic [IW-1:0]        rrow, rcol;

  // Cell broadcast and read-out.
  cell_ctrl_t       ctrl;
  logic [IW-1:0]    q_idx;
  logic [IW-1:0]    q_owner, q_link;
  pot_t             q_pot;
  logic [COST_BITS:0] cost_bus;

  // Scan chain between cells; entry k feeds cell k.
  logic          pv_w    [MAX_DIM+2];
  pot_t          pu_w    [MAX_DIM+2];
  logic [IW-1:0] pj0_w   [MAX_DIM+2];
  pot_t          pdel_w  [MAX_DIM+2];
  logic [IW-1:0] pj1_w   [MAX_DIM+2];
  logic [IW-1:0] pown_w  [MAX_DIM+2];
  pot_t          ppot_w  [MAX_DIM+2];
  logic [IW-1:0] qo_w    [MAX_DIM+1];
  logic [IW-1:0] ql_w    [MAX_DIM+1];
  pot_t          qp_w    [MAX_DIM+1];

  logic            in_acc;
  logic            out_free;
  logic [PW-1:0]   area;
  logic [IW-1:0]   rows_sat, cols_sat;
  logic [TW-1:0]   total;
  logic            row_done;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign area       = PW'(rows_q) * PW'(cols_q);
  assign total      = TW'(rows_q) + TW'(cols_q) - TW'(m_q);

  // Counts above the largest size saturate.
  assign rows_sat = (32'(row_count_i) > MAX_DIM) ? IW'(MAX_DIM) : IW'(row_count_i);
  assign cols_sat = (32'(col_count_i) > MAX_DIM) ? IW'(MAX_DIM) : IW'(col_count_i);

  // Scan packet enters column cell 0 with the first cost read.
  assign pv_w[0]   = (state_q == ST_SCAN) && (sc_q == IW'(1));
  assign pu_w[0]   = u_q;
  assign pj0_w[0]  = j0_q;
  assign pdel_w[0] = SLACK_MAX;
  assign pj1_w[0]  = '0;
  assign pown_w[0] = '0;
  assign ppot_w[0] = '0;

  assign cost_bus = pad_q ? {1'b1, {COST_BITS{1'b0}}} : {1'b0, rd_q};

  for (genvar k = 0; k <= MAX_DIM; k++) begin : g_cell
    gmca_cell #(
      .MAX_DIM   (MAX_DIM),
      .COST_BITS (COST_BITS),
      .IDX       (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .n_i         (n_q),
      .ctrl_i      (ctrl),
      .mark_idx_i  (j0_q),
      .delta_i     (delta_q),
      .wr_idx_i    (j0_q),
      .wr_owner_i  (q_owner),
      .wr_pot_i    (q_pot),
      .row_sel_i   (row_q),
      .cost_i      (cost_bus),
      .pv_i        (pv_w[k]),
      .pu_i        (pu_w[k]),
      .pj0_i       (pj0_w[k]),
      .pdelta_i    (pdel_w[k]),
      .pj1_i       (pj1_w[k]),
      .pown_i      (pown_w[k]),
      .ppot_i      (ppot_w[k]),
      .pv_o        (pv_w[k+1]),
      .pu_o        (pu_w[k+1]),
      .pj0_o       (pj0_w[k+1]),
      .pdelta_o    (pdel_w[k+1]),
      .pj1_o       (pj1_w[k+1]),
      .pown_o      (pown_w[k+1]),
      .ppot_o      (ppot_w[k+1]),
      .query_idx_i (q_idx),
      .q_owner_o   (qo_w[k]),
      .q_link_o    (ql_w[k]),
      .q_pot_o     (qp_w[k])
    );
  end

  // Combine the read-out of the addressed cell.
  always_comb begin
    q_owner = '0;
    q_link  = '0;
    q_pot   = '0;
    for (int k = 0; k <= MAX_DIM; k++) begin
      q_owner = q_owner | qo_w[k];
      q_link  = q_link | ql_w[k];
      q_pot   = q_pot | qp_w[k];
    end
  end

  // Cell address for owner, link and potential lookups.
  always_comb begin
    unique case (state_q)
      ST_AUG_B:                      q_idx = aj1_q;
      ST_CHK_A, ST_EM_PAIR:          q_idx = cj_q;
      default:                       q_idx = j0_q;
    endcase
  end

  // Cost memory read address: scanned row or owner row during the gate check.
  always_comb begin
    if (state_q == ST_CHK_A) begin
      rrow = q_owner;
      rcol = cj_q;
    end else begin
      rrow = i0_q;
      rcol = sc_q;
    end
    raddr = AW'((PW'(rrow) - PW'(1)) * PW'(cols_q) + PW'(rcol) - PW'(1));
    waddr = AW'(load_q);
    mem_we = in_acc && (command_i == CMD_COST) && active_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cost_mem[waddr] <= COST_BITS'(cost_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= cost_mem[raddr];
  end

  // Next state and datapath of the sequencer.
  always_comb begin
    state_d    = state_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    n_d        = n_q;
    gate_d     = gate_q;
    load_d     = load_q;
    active_d   = active_q;
    row_d      = row_q;
    j0_d       = j0_q;
    i0_d       = i0_q;
    sc_d       = sc_q;
    u_d        = u_q;
    delta_d    = delta_q;
    pot1_d     = pot1_q;
    j1_d       = j1_q;
    own1_d     = own1_q;
    aj1_d      = aj1_q;
    guard_d    = guard_q;
    cj_d       = cj_q;
    cown_d     = cown_q;
    er_d       = er_q;
    m_d        = m_q;
    ok_d       = ok_q;
    matched_d  = matched_q;
    row_hit_d  = row_hit_q;
    ecnt_d     = ecnt_q;
    pad_d      = !((i0_q != '0) && (i0_q <= rows_q) && (sc_q <= cols_q));
    ctrl       = '0;
    out_load   = 1'b0;
    kind_n     = KIND_PAIR;
    orow_n     = '0;
    ocol_n     = '0;
    row_done   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (command_i == CMD_START) begin
            rows_d   = rows_sat;
            cols_d   = cols_sat;
            gate_d   = gate_threshold_i;
            load_d   = '0;
            active_d = (rows_sat != '0) && (cols_sat != '0);
            if ((rows_sat == '0) || (cols_sat == '0)) begin
              // Nothing to solve: list every index as unmatched.
              matched_d  = '0;
              row_hit_d  = '0;
              m_d        = '0;
              ecnt_d     = '0;
              er_d       = IW'(1);
              state_d    = ST_EM_ROW;
            end
          end else if (active_q) begin
            load_d = load_q + PW'(1);
            if (load_q + PW'(1) == area) begin
              active_d       = 1'b0;
              n_d            = (rows_q > cols_q) ? rows_q : cols_q;
              ctrl.clear_job = 1'b1;
              row_d          = IW'(1);
              matched_d      = '0;
              row_hit_d      = '0;
              m_d            = '0;
              state_d        = ST_ROW;
            end
          end
        end
      end

      ST_ROW: begin
        ctrl.row_init = 1'b1;
        j0_d    = '0;
        i0_d    = row_q;
        u_d     = '0;
        guard_d = '0;
        state_d = ST_MARK;
      end

      ST_MARK: begin
        ctrl.mark = 1'b1;
        sc_d      = IW'(1);
        state_d   = ST_SCAN;
      end

      ST_SCAN: begin
        sc_d = sc_q + IW'(1);
        if (sc_q == n_q) begin
          state_d = ST_WAIT;
        end
      end

      ST_WAIT: begin
        if (pv_w[MAX_DIM+1]) begin
          delta_d = pdel_w[MAX_DIM+1];
          j1_d    = pj1_w[MAX_DIM+1];
          own1_d  = pown_w[MAX_DIM+1];
          pot1_d  = ppot_w[MAX_DIM+1];
          if (pj1_w[MAX_DIM+1] == '0) begin
            guard_d = '0;
            state_d = ST_AUG_A;
          end else begin
            state_d = ST_UPD;
          end
        end
      end

      ST_UPD: begin
        ctrl.update = 1'b1;
        j0_d    = j1_q;
        guard_d = guard_q + GW'(1);
        if ((own1_q == '0) || (guard_q == GW'(n_q))) begin
          guard_d = '0;
          state_d = ST_AUG_A;
        end else begin
          i0_d    = own1_q;
          u_d     = pot1_q;
          state_d = ST_MARK;
        end
      end

      ST_AUG_A: begin
        aj1_d   = q_link;
        state_d = ST_AUG_B;
      end

      ST_AUG_B: begin
        ctrl.write = 1'b1;
        j0_d    = aj1_q;
        guard_d = guard_q + GW'(1);
        if ((aj1_q == '0) || (guard_q == GW'(n_q))) begin
          row_done = 1'b1;
        end else begin
          state_d = ST_AUG_A;
        end
        if (row_done) begin
          if (row_q == n_q) begin
            cj_d    = IW'(1);
            state_d = ST_CHK_A;
          end else begin
            row_d   = row_q + IW'(1);
            state_d = ST_ROW;
          end
        end
      end

      ST_CHK_A: begin
        ok_d    = (q_owner != '0) && (q_owner <= rows_q) && (cj_q <= cols_q);
        cown_d  = q_owner;
        state_d = ST_CHK_B;
      end

      ST_CHK_B: begin
        if (ok_q && (32'(rd_q) <= 32'(gate_q))) begin
          matched_d[cj_q]   = 1'b1;
          row_hit_d[cown_q] = 1'b1;
          m_d               = m_q + IW'(1);
        end
        cj_d = cj_q + IW'(1);
        if (cj_q == n_q) begin
          cj_d    = IW'(1);
          ecnt_d  = '0;
          state_d = ST_EM_PAIR;
        end else begin
          state_d = ST_CHK_A;
        end
      end

      ST_EM_PAIR: begin
        if (cj_q > n_q) begin
          er_d    = IW'(1);
          state_d = ST_EM_ROW;
        end else if (out_free) begin
          cj_d = cj_q + IW'(1);
          if (matched_q[cj_q]) begin
            out_load = 1'b1;
            kind_n   = KIND_PAIR;
            orow_n   = 4'(q_owner - IW'(1));
            ocol_n   = 4'(cj_q - IW'(1));
          end
        end
      end

      ST_EM_ROW: begin
        if (er_q > rows_q) begin
          er_d    = IW'(1);
          state_d = ST_EM_COL;
        end else if (out_free) begin
          er_d = er_q + IW'(1);
          if (!row_hit_q[er_q]) begin
            out_load = 1'b1;
            kind_n   = KIND_ROW;
            orow_n   = 4'(er_q - IW'(1));
          end
        end
      end

      ST_EM_COL: begin
        if (er_q > cols_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          er_d = er_q + IW'(1);
          if (!matched_q[er_q]) begin
            out_load = 1'b1;
            kind_n   = KIND_COL;
            ocol_n   = 4'(er_q - IW'(1));
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      ecnt_d = ecnt_q + TW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rows_q     <= '0;
      cols_q     <= '0;
      n_q        <= '0;
      gate_q     <= '0;
      load_q     <= '0;
      active_q   <= 1'b0;
      row_q      <= '0;
      j0_q       <= '0;
      i0_q       <= '0;
      sc_q       <= '0;
      guard_q    <= '0;
      j1_q       <= '0;
      own1_q     <= '0;
      aj1_q      <= '0;
      cj_q       <= '0;
      cown_q     <= '0;
      er_q       <= '0;
      m_q        <= '0;
      ok_q       <= 1'b0;
      matched_q  <= '0;
      row_hit_q  <= '0;
      ecnt_q     <= '0;
      pad_q      <= 1'b1;
    end else begin
      state_q    <= state_d;
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      n_q        <= n_d;
      gate_q     <= gate_d;
      load_q     <= load_d;
      active_q   <= active_d;
      row_q      <= row_d;
      j0_q       <= j0_d;
      i0_q       <= i0_d;
      sc_q       <= sc_d;
      guard_q    <= guard_d;
      j1_q       <= j1_d;
      own1_q     <= own1_d;
      aj1_q      <= aj1_d;
      cj_q       <= cj_d;
      cown_q     <= cown_d;
      er_q       <= er_d;
      m_q        <= m_d;
      ok_q       <= ok_d;
      matched_q  <= matched_d;
      row_hit_q  <= row_hit_d;
      ecnt_q     <= ecnt_d;
      pad_q      <= pad_d;
    end
  end

  // Potential and delta registers.
  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    delta_q <= delta_d;
    pot1_q  <= pot1_d;
  end

  // Output register; a new result loads only when the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q  <= kind_n;
      orow_q  <= orow_n;
      ocol_q  <= ocol_n;
      olast_q <= (ecnt_q + TW'(1)) == total;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign row_index_o   = orow_q;
  assign col_index_o   = ocol_q;
  assign last_of_run_o = olast_q;

endmodule

// ===== rtl/core/gmca_cell.sv =====
// ----------------------------------------------------------------------------
// Gated min-cost assignment: column cell
// Holds one column's potential, owner, owner potential, slack and back link.
// A scan packet passes through the row of cells one cell per cycle and picks
// up the smallest slack with its column, owner and owner potential.
// ----------------------------------------------------------------------------
module gmca_cell #(
  parameter int MAX_DIM   = 16,
  parameter int COST_BITS = 16,
  parameter int IDX       = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [$clog2(MAX_DIM+1)-1:0]     n_i,
  input  gmca_pkg::cell_ctrl_t             ctrl_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]     mark_idx_i,
  input  gmca_pkg::pot_t                   delta_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]     wr_idx_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]     wr_owner_i,
  input  gmca_pkg::pot_t                   wr_pot_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]     row_sel_i,
  input  logic [COST_BITS:0]               cost_i,
  input  logic                             pv_i,
  input  gmca_pkg::pot_t                   pu_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]     pj0_i,
  input  gmca_pkg::pot_t                   pdelta_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]     pj1_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]     pown_i,
  input  gmca_pkg::pot_t                   ppot_i,
  output logic                             pv_o,
  output gmca_pkg::pot_t                   pu_o,
  output logic [$clog2(MAX_DIM+1)-1:0]     pj0_o,
  output gmca_pkg::pot_t                   pdelta_o,
  output logic [$clog2(MAX_DIM+1)-1:0]     pj1_o,
  output logic [$clog2(MAX_DIM+1)-1:0]     pown_o,
  output gmca_pkg::pot_t                   ppot_o,
  input  logic [$clog2(MAX_DIM+1)-1:0]     query_idx_i,
  output logic [$clog2(MAX_DIM+1)-1:0]     q_owner_o,
  output logic [$clog2(MAX_DIM+1)-1:0]     q_link_o,
  output gmca_pkg::pot_t                   q_pot_o
);
  import gmca_pkg::*;

  localparam int IW = $clog2(MAX_DIM+1);
  localparam logic [IW-1:0] MY = IW'(IDX);

  logic          visited_q;
  pot_t          slack_q;
  pot_t          v_q;
  pot_t          opot_q;
  logic [IW-1:0] owner_q;
  logic [IW-1:0] link_q;

  logic          in_use;
  logic          scan_here;
  pot_t          cur;
  pot_t          new_slack;
  logic          take_link;
  logic          win;

  // Slack of this column against the scanned row.
  assign in_use    = (MY != '0) && (MY <= n_i);
  assign scan_here = pv_i && in_use && !visited_q;
  assign cur       = $signed(POT_W'(cost_i)) - pu_i - v_q;
  assign take_link = cur < slack_q;
  assign new_slack = take_link ? cur : slack_q;
  assign win       = new_slack < pdelta_i;

  // Packet stage towards the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_o <= 1'b0;
    end else begin
      pv_o <= pv_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pu_o  <= pu_i;
    pj0_o <= pj0_i;
    if (scan_here && win) begin
      pdelta_o <= new_slack;
      pj1_o    <= MY;
      pown_o   <= owner_q;
      ppot_o   <= opot_q;
    end else begin
      pdelta_o <= pdelta_i;
      pj1_o    <= pj1_i;
      pown_o   <= pown_i;
      ppot_o   <= ppot_i;
    end
  end

  // Column state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= 1'b0;
      slack_q   <= SLACK_MAX;
      v_q       <= '0;
      opot_q    <= '0;
      owner_q   <= '0;
      link_q    <= '0;
    end else begin
      priority if (ctrl_i.clear_job) begin
        visited_q <= 1'b0;
        slack_q   <= SLACK_MAX;
        v_q       <= '0;
        opot_q    <= '0;
        owner_q   <= '0;
        link_q    <= '0;
      end else if (ctrl_i.row_init) begin
        visited_q <= 1'b0;
        slack_q   <= SLACK_MAX;
        if (MY == '0) begin
          owner_q <= row_sel_i;
          opot_q  <= '0;
        end
      end else if (ctrl_i.mark) begin
        if (mark_idx_i == MY) begin
          visited_q <= 1'b1;
        end
      end else if (ctrl_i.update) begin
        if (MY <= n_i) begin
          if (visited_q) begin
            opot_q <= opot_q + delta_i;
            v_q    <= v_q - delta_i;
          end else begin
            slack_q <= slack_q - delta_i;
          end
        end
      end else if (ctrl_i.write) begin
        if (wr_idx_i == MY) begin
          owner_q <= wr_owner_i;
          opot_q  <= wr_pot_i;
        end
      end else if (scan_here) begin
        slack_q <= new_slack;
        if (take_link) begin
          link_q <= pj0_i;
        end
      end
    end
  end

  // Read-out for the sequencer; only the addressed cell drives nonzero.
  logic hit;
  assign hit       = query_idx_i == MY;
  assign q_owner_o = hit ? owner_q : '0;
  assign q_link_o  = hit ? link_q : '0;
  assign q_pot_o   = hit ? opot_q : '0;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gated min-cost assignment testbench
// Streams start and cost requests into the block, solves each job with a
// behavioral Hungarian solver and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import gmca_pkg::*;

  localparam int DIM = 16;
  localparam longint PAD = 64'sd65536;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  rows;
    logic [4:0]  cols;
    logic [15:0] gate;
    logic [15:0] cost;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] row;
    logic [3:0] col;
    logic       last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = CMD_START;
  logic [4:0]  row_count_i = '0;
  logic [4:0]  col_count_i = '0;
  logic [15:0] gate_threshold_i = '0;
  logic [15:0] cost_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [3:0]  row_index_o;
  logic [3:0]  col_index_o;
  logic        last_of_run_o;

  gated_min_cost_assignment dut (.*);

  request_t pending_requests[$];
  result_t  expected_results[$];
  int       error_count = 0;
  int       results_seen = 0;
  int       jobs_started = 0;
  bit       quiet_phase = 1'b0;

  // Predictor state.
  logic [15:0] matrix[DIM*DIM];
  int unsigned job_r = 0, job_c = 0, job_g = 0, load_pos = 0;
  bit          loading = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Appends one request to the stimulus queue.
  task automatic add_request(input request_t req);
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Appends one result to the expected queue.
  task automatic add_expected(input result_t res);
    expected_results.insert(expected_results.size(), res);
  endtask

  // Adds the unmatched indices and marks the last result of the job.
  task automatic list_unmatched(input bit row_taken[DIM], input bit col_taken[DIM],
                                input int first);
    result_t res;
    for (int i = 0; i < job_r; i++) begin
      if (!row_taken[i]) begin
        res = '{KIND_ROW, 4'(i), 4'd0, 1'b0};
        add_expected(res);
      end
    end
    for (int j = 0; j < job_c; j++) begin
      if (!col_taken[j]) begin
        res = '{KIND_COL, 4'd0, 4'(j), 1'b0};
        add_expected(res);
      end
    end
    if (expected_results.size() > first) begin
      expected_results[expected_results.size()-1].last = 1'b1;
    end
  endtask

  function automatic longint cell_cost(int i, int j);
    if (i >= 1 && j >= 1 && i <= job_r && j <= job_c) begin
      return longint'(matrix[(i-1)*job_c + (j-1)]);
    end
    return PAD;
  endfunction

  // Shortest augmenting path solve and listing of the gated pairs.
  task automatic solve_assignment();
    longint u[DIM+1], v[DIM+1], minv[DIM+1], delta, cur;
    int     owner[DIM+1], way[DIM+1];
    bit     used[DIM+1];
    bit     row_taken[DIM], col_taken[DIM];
    int     n, j0, j1, i0, first;
    result_t res;
    n = (job_r > job_c) ? job_r : job_c;
    first = expected_results.size();
    for (int j = 0; j <= DIM; j++) begin
      u[j] = 0; v[j] = 0; owner[j] = 0; way[j] = 0;
    end
    for (int i = 0; i < DIM; i++) begin
      row_taken[i] = 0; col_taken[i] = 0;
    end
    for (int i = 1; i <= n; i++) begin
      j0 = 0;
      owner[0] = i;
      for (int j = 0; j <= n; j++) begin
        minv[j] = 64'h7fff_ffff_ffff_ffff; used[j] = 0;
      end
      for (int g = 0; g <= n; g++) begin
        j1 = 0;
        delta = 64'h7fff_ffff_ffff_ffff;
        used[j0] = 1;
        i0 = owner[j0];
        for (int j = 1; j <= n; j++) begin
          if (!used[j]) begin
            cur = cell_cost(i0, j) - u[i0] - v[j];
            if (cur < minv[j]) begin
              minv[j] = cur; way[j] = j0;
            end
            if (minv[j] < delta) begin
              delta = minv[j]; j1 = j;
            end
          end
        end
        if (j1 == 0) break;
        for (int j = 0; j <= n; j++) begin
          if (used[j]) begin
            u[owner[j]] += delta; v[j] -= delta;
          end else begin
            minv[j] -= delta;
          end
        end
        j0 = j1;
        if (owner[j0] == 0) break;
      end
      for (int g = 0; g <= n; g++) begin
        j1 = way[j0];
        owner[j0] = owner[j1];
        j0 = j1;
        if (j0 == 0) break;
      end
    end
    for (int j = 1; j <= n; j++) begin
      if (owner[j] >= 1 && owner[j] <= job_r && j <= job_c &&
          cell_cost(owner[j], j) <= longint'(job_g)) begin
        res = '{KIND_PAIR, 4'(owner[j]-1), 4'(j-1), 1'b0};
        add_expected(res);
        row_taken[owner[j]-1] = 1;
        col_taken[j-1] = 1;
      end
    end
    list_unmatched(row_taken, col_taken, first);
  endtask

  // Predicts the results of one accepted request.
  task automatic predict_results(input request_t req);
    bit no_rows[DIM], no_cols[DIM];
    for (int i = 0; i < DIM; i++) begin
      no_rows[i] = 0; no_cols[i] = 0;
    end
    if (req.cmd == CMD_START) begin
      job_r = (req.rows > DIM) ? DIM : req.rows;
      job_c = (req.cols > DIM) ? DIM : req.cols;
      job_g = req.gate;
      load_pos = 0;
      loading = (job_r != 0 && job_c != 0);
      jobs_started++;
      if (!loading) list_unmatched(no_rows, no_cols, expected_results.size());
    end else if (loading) begin
      matrix[load_pos] = req.cost;
      load_pos++;
      if (load_pos >= job_r * job_c) begin
        loading = 1'b0;
        solve_assignment();
      end
    end
  endtask

  function automatic request_t start_req(int r, int c, int g);
    return '{CMD_START, 5'(r), 5'(c), 16'(g), 16'($urandom)};
  endfunction

  function automatic request_t cost_req(int v);
    return '{CMD_COST, 5'($urandom), 5'($urandom), 16'($urandom), 16'(v)};
  endfunction

  // Queues a full job; mode picks the flavor of the cost values.
  task automatic add_job(int r, int c, int g, int mode);
    int v;
    add_request(start_req(r, c, g));
    for (int k = 0; k < r * c; k++) begin
      case (mode)
        0: begin
          v = $urandom;
        end
        1: begin
          v = $urandom_range(0, 3);
        end
        2: begin
          v = 65535;
        end
        default: begin
          v = $urandom_range(0, 1) ? 0 : 65535;
        end
      endcase
      add_request(cost_req(v));
    end
  endtask

  // Request driver with random idle bursts.
  int idle_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_results('{command_i, row_count_i, col_count_i, gate_threshold_i,
                          cost_value_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          request_t req;
          req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          command_i <= req.cmd;
          row_count_i <= req.rows;
          col_count_i <= req.cols;
          gate_threshold_i <= req.gate;
          cost_value_i <= req.cost;
          if (!quiet_phase && $urandom_range(0, 4) == 0) idle_left = $urandom_range(1, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stall bursts.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d row %0d col %0d",
                                    result_kind_o, row_index_o, col_index_o));
        end else begin
          result_t exp_res;
          exp_res = expected_results.pop_front();
          if (result_kind_o !== exp_res.kind)
            report_mismatch($sformatf("kind %0d, want %0d", result_kind_o, exp_res.kind));
          if (row_index_o !== exp_res.row)
            report_mismatch($sformatf("row %0d, want %0d", row_index_o, exp_res.row));
          if (col_index_o !== exp_res.col)
            report_mismatch($sformatf("col %0d, want %0d", col_index_o, exp_res.col));
          if (last_of_run_o !== exp_res.last)
            report_mismatch($sformatf("last %0b, want %0b", last_of_run_o, exp_res.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int r, c;
    // Directed: empty jobs, saturation, extremes, ties, stray costs, restart.
    add_request(cost_req(16'hffff));
    add_request(start_req(0, 0, 0));
    add_request(start_req(0, 31, 65535));
    add_request(start_req(31, 0, 0));
    add_job(1, 1, 0, 2);
    add_job(1, 1, 65535, 2);
    add_request(cost_req(0));
    add_job(2, 3, 1, 1);
    add_request(start_req(2, 2, 100));
    add_request(cost_req(5));
    add_job(3, 1, 65535, 3);
    // Random: mostly small jobs, a few with a full-size side.
    for (int k = 0; k < 34; k++) begin
      if (k % 12 == 11) begin
        r = 16; c = $urandom_range(1, 2);
        if ($urandom_range(0, 1)) begin
          int t;
          t = r; r = c; c = t;
        end
      end else begin
        r = $urandom_range(0, 4); c = $urandom_range(0, 4);
      end
      if ($urandom_range(0, 9) == 0) add_request(cost_req($urandom));
      if ($urandom_range(0, 9) == 0) begin
        add_request(start_req(3, 3, $urandom));
        add_request(cost_req($urandom));
      end
      add_job(r, c, $urandom_range(0, 2) == 0 ? 65535 : $urandom, $urandom_range(0, 3));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_requests.size() < 20);
    quiet_phase = 1'b1;
    wait (pending_requests.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("Ran %0d jobs and checked %0d results.", jobs_started, results_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 6000000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/gmca_pkg.sv
rtl/core/gmca_cell.sv
rtl/core/gated_min_cost_assignment.sv
dv/testbench.sv
